FILE: rtl/fpcrn_pkg.sv
// Shared types and constants for the fixed-point Newton cube root block.
`default_nettype none
package fpcrn_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TDATA_W        = 32;
    localparam int CFG_W          = 6;
    localparam logic [CFG_W-1:0] MAX_ITER_RST = 6'd8;
    localparam int DIVISOR_THREE  = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_CHK,
        ST_SQCHK,
        ST_DIVQ,
        ST_DIV3,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic guess;
        logic mul;
        logic start_q;
        logic start_3;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic scan_done;
        logic iter_end;
        logic sq_zero;
        logic div_done;
        logic conv;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/fpcrn_div.sv
// Restoring divider for the Newton quotient, with quotient saturation to the largest positive value.
`default_nettype none
module fpcrn_div
    import fpcrn_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [DATA_WIDTH+FRAC_BITS-1:0] num,
    input  wire logic [DATA_WIDTH-2:0]           den,
    output logic                                 done,
    output logic [DATA_WIDTH-2:0]                quo
);
    localparam int MW   = DATA_WIDTH - 1;
    localparam int TW   = FRAC_BITS + 1;
    localparam int CW   = (TW > MW) ? TW : MW;
    localparam int CNTW = $clog2(DATA_WIDTH);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg;
    logic [MW-1:0]   rem_reg, lo_reg, den_reg, quo_reg;
    logic [TW-1:0]   top;
    logic [CW-1:0]   top_ext;
    logic            sat;
    logic [MW:0]     trial, diff;
    logic            ge;
    logic [MW-1:0]   rem_next;

    // quotient needs more than MW bits exactly when the top part reaches the divisor
    assign top     = num[DATA_WIDTH+FRAC_BITS-1:MW];
    assign top_ext = CW'(top);
    assign sat     = top_ext >= CW'(den);

    assign trial    = {rem_reg, lo_reg[MW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[MW-1:0] : trial[MW-1:0];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            if (sat) begin
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg && cnt_reg == CNTW'(1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            lo_reg  <= num[MW-1:0];
            rem_reg <= top_ext[MW-1:0];
            quo_reg <= sat ? '1 : '0;
            cnt_reg <= CNTW'(MW);
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            lo_reg  <= lo_reg << 1;
            quo_reg <= {quo_reg[MW-2:0], ge};
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

FILE: rtl/fpcrn_dp.sv
// Datapath: operand load, top-bit scan, first guess, squaring and Newton update.
`default_nettype none
module fpcrn_dp
    import fpcrn_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [DATA_WIDTH-1:0] in_value,
    input  wire logic [CFG_W-1:0]      max_iter,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic [TDATA_W-1:0]         root
);
    localparam int MW  = DATA_WIDTH - 1;
    localparam int NW  = DATA_WIDTH + FRAC_BITS;
    localparam int PW  = 2 * MW;
    localparam int P3W = 2 * DATA_WIDTH + 2;
    localparam int K3  = DATA_WIDTH + 2;
    localparam int PCW = $clog2(DATA_WIDTH);
    localparam int SHW = $clog2(DATA_WIDTH + FRAC_BITS + 1) + 1;
    localparam logic [MW-1:0] QMAX = '1;
    // ceil(2^K3 / 3): exact floor division by three for any sum below 2^(DATA_WIDTH+1)
    localparam logic [DATA_WIDTH:0] RECIP3 =
        (DATA_WIDTH+1)'(((64'd1 << K3) + 64'd2) / DIVISOR_THREE);

    logic signed [DATA_WIDTH-1:0] v, v_neg;
    logic [MW-1:0]    mag;
    logic             neg_reg;
    logic [MW-1:0]    x_reg, x0_reg, x1_reg, sc_reg;
    logic [PCW-1:0]   m_reg;
    logic [CFG_W-1:0] cnt_reg;
    logic [PW-1:0]    prod_reg, prod_sh;
    logic [P3W-1:0]   p3_reg, p3_sh;
    logic [MW-1:0]    sq;
    logic [MW-1:0]    x_new;
    logic signed [SHW-1:0] d, half, sh;
    logic [SHW-1:0]   shu;
    logic [MW-1:0]    guess;
    logic [DATA_WIDTH:0] sum;
    logic [NW-1:0]    div_num;
    logic [MW-1:0]    div_den, quo;
    logic             div_done;
    logic signed [DATA_WIDTH-1:0] r;
    logic [TDATA_W-1:0] root_reg;

    assign v     = in_value;
    assign v_neg = -v;

    // magnitude, with the most negative value held at the largest positive
    always_comb begin
        if (!v[DATA_WIDTH-1]) begin
            mag = v[MW-1:0];
        end else if (v[MW-1:0] == '0) begin
            mag = QMAX;
        end else begin
            mag = v_neg[MW-1:0];
        end
    end

    // first guess 2^s, s = trunc((m - F) / 2) + F, clamped
    always_comb begin
        d    = SHW'(m_reg) - SHW'(FRAC_BITS);
        half = d[SHW-1] ? -((-d) >>> 1) : (d >>> 1);
        sh   = half + SHW'(FRAC_BITS);
        if (sh[SHW-1]) begin
            shu = '0;
        end else if (sh > SHW'(MW - 1)) begin
            shu = SHW'(MW - 1);
        end else begin
            shu = sh;
        end
        guess = MW'(1) << shu;
    end

    assign prod_sh = prod_reg >> FRAC_BITS;
    assign sq      = (prod_sh[PW-1:MW] != '0) ? QMAX : prod_sh[MW-1:0];

    assign sum     = (DATA_WIDTH+1)'(quo) + (DATA_WIDTH+1)'({x0_reg, 1'b0});
    assign div_num = NW'(x_reg) << FRAC_BITS;
    assign div_den = sq;

    // divide the sum by three through the registered reciprocal product
    assign p3_sh = p3_reg >> K3;
    assign x_new = (p3_sh[P3W-1:MW] != '0) ? QMAX : p3_sh[MW-1:0];

    fpcrn_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_q),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg <= v[DATA_WIDTH-1];
            x_reg   <= mag;
            x1_reg  <= mag;
            sc_reg  <= mag;
            m_reg   <= PCW'(MW);
            cnt_reg <= '0;
        end
        // shift until the top bit shows
        if (cmd.scan_step && !sc_reg[MW-1]) begin
            sc_reg <= sc_reg << 1;
            m_reg  <= m_reg - PCW'(1);
        end
        if (cmd.guess) begin
            x0_reg <= guess;
        end
        if (cmd.mul) begin
            prod_reg <= PW'(x0_reg) * PW'(x0_reg);
        end
        if (cmd.start_3) begin
            p3_reg <= P3W'(sum) * P3W'(RECIP3);
        end
        if (cmd.update) begin
            x1_reg  <= x_new;
            x0_reg  <= x_new;
            cnt_reg <= cnt_reg + CFG_W'(1);
        end
        if (cmd.out_load) begin
            root_reg <= TDATA_W'(r);
        end
    end

    assign r = neg_reg ? -$signed({1'b0, x1_reg}) : $signed({1'b0, x1_reg});

    assign status.zero      = (x_reg == '0);
    assign status.scan_done = sc_reg[MW-1];
    assign status.iter_end  = (cnt_reg == max_iter);
    assign status.sq_zero   = (sq == '0);
    assign status.div_done  = div_done;
    assign status.conv      = (x_new == x0_reg);

    assign root = root_reg;

endmodule
`default_nettype wire

FILE: rtl/fpcrn_ctrl.sv
// Controller state machine sequencing the Newton steps and the result handshake.
`default_nettype none
module fpcrn_ctrl
    import fpcrn_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = status.zero ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_done) begin
                    cmd.guess  = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (status.iter_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = ST_SQCHK;
                end
            end
            ST_SQCHK: begin
                if (status.sq_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.start_q = 1'b1;
                    state_next  = ST_DIVQ;
                end
            end
            ST_DIVQ: begin
                if (status.div_done) begin
                    cmd.start_3 = 1'b1;
                    state_next  = ST_DIV3;
                end
            end
            ST_DIV3: begin
                // reciprocal product, registered on entry to this state, is ready here
                cmd.update = 1'b1;
                state_next = status.conv ? ST_DONE : ST_CHK;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/fixed_point_cube_root_newton.sv
// From accept to result valid: operand load, top-bit scan, then per Newton step a check,
// a squaring, a divider pass and a reciprocal divide by three, for at most max_iterations
// steps; the loop ends early when the estimate settles, and a zero operand skips to done.
// One item at a time; the next is accepted once the controller returns to idle after the
// result is loaded. A waiting result does not block that input, only the result after it.
// Synchronous active-low reset clears the controller and sets max_iterations to 8.
`default_nettype none
module fixed_point_cube_root_newton
    import fpcrn_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,   // max_iterations
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,       // [31:0] value
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata        // [31:0] root
);
    logic [CFG_W-1:0] max_iter_reg;
    cmd_t             cmd;
    status_t          status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RST;
        end else if (cfg_wr_en) begin
            max_iter_reg <= cfg_wr_data;
        end
    end

    fpcrn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpcrn_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_value (s_tdata[DATA_WIDTH-1:0]),
        .max_iter (max_iter_reg),
        .cmd      (cmd),
        .status   (status),
        .root     (m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was in progress");

    a_out_clear_on_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_root_sign_extended: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_W-1] == m_tdata[DATA_WIDTH-1]))
        else $error("root not sign-extended from the data width");

    a_load_only_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (s_tready && m_tvalid))
        else $error("result loaded without returning to idle");

endmodule
`default_nettype wire

FILE: bench/fixed_point_cube_root_newton_test.sv
// Self-checking bench for the fixed-point Newton cube root block.
`timescale 1ns / 100ps
`default_nettype none

module fixed_point_cube_root_newton_test;
    import fpcrn_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint QMAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam int IDLE_LIMIT = 200000;

    // Expected roots and the cube root predictor.
    class root_scoreboard;
        logic [CFG_W-1:0] iter_limit;
        logic [31:0] roots_due[$];
        int mismatches;
        int checked;

        function new();
            iter_limit = MAX_ITER_RST;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint sat(longint v);
            return (v > QMAX) ? QMAX : v;
        endfunction

        function longint cube_root_mag(longint x, int steps);
            int top;
            int shamt;
            longint x0;
            longint x1;
            longint sq;
            longint q;
            longint total;
            top = 0;
            for (int k = DW; k > 0; k--)
                if (top == 0 && x[k-1]) top = k;
            shamt = ((top - FB) / 2) + FB;
            if (shamt < 0) shamt = 0;
            if (shamt > DW - 2) shamt = DW - 2;
            x0 = 64'sd1 <<< shamt;
            x1 = x;
            for (int i = 0; i < steps; i++) begin
                sq = sat((x0 * x0) >>> FB);
                if (sq == 0) break;
                q = sat(longint'(64'(x << FB) / 64'(sq)));
                total = q + 2 * x0;
                x1 = sat(total / 3);
                if (x1 == x0) break;
                x0 = x1;
            end
            return (x1 < 0) ? -x1 : x1;
        endfunction

        function void note_operand(logic [31:0] raw);
            longint v;
            longint r;
            v = longint'($signed(raw[DW-1:0]));
            if (v == 0) r = 0;
            else if (v < 0) r = -cube_root_mag(sat(-v), iter_limit);
            else r = cube_root_mag(v, iter_limit);
            roots_due.push_back(r[31:0]);
        endfunction

        function void check_root(logic [31:0] got);
            logic [31:0] want;
            if (roots_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected root %h", got);
                return;
            end
            want = roots_due.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("root mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [TDATA_W-1:0] m_tdata;

    root_scoreboard roots = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    int sent = 0;

    always #1 aclk = ~aclk;

    fixed_point_cube_root_newton dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Receiver: random stall, or a long hold-off when asked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) roots.check_root(m_tdata);
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("fixed_point_cube_root_newton_test: errors");
            $finish;
        end
    end

    // Valid stays high between back-to-back items; drop it only for idle gaps.
    task automatic send_operand(logic [31:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        roots.note_operand(v);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (roots.roots_due.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    task automatic set_iterations(logic [CFG_W-1:0] n);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        roots.iter_limit = n;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        int width;
        width = $urandom_range(32, 1);
        v = $urandom;
        if (width < 32) v = v & ((32'h1 << width) - 1);
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_operand(random_operand());
    endtask

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0008_0000,
                     32'h001B_0000, 32'hFFE5_0000, 32'h0000_8000, 32'h0000_0002,
                     32'h4000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF,
                     32'h0100_0000};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset value of the step limit first, then the extremes.
        foreach (directed[i]) send_operand(directed[i]);
        set_iterations(6'd0);
        foreach (directed[i]) send_operand(directed[i]);
        set_iterations(6'd63);
        foreach (directed[i]) send_operand(directed[i]);
        set_iterations(6'd32);
        random_phase(150, 0, 0);
        set_iterations(6'd1);
        random_phase(120, 61, 0);
        set_iterations(6'd8);
        random_phase(120, 0, 61);

        // Hold the receiver off so the block backs up its input.
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(10, 0, 0);
        join
        drain();
        set_iterations(6'($urandom_range(63)));
        random_phase(120, 7, 7);
        set_iterations(6'd3);
        random_phase(100, 0, 0);

        drain();
        $display("covered %0d operands over step limits 0..63, %0d roots checked",
                 sent, roots.checked);
        if (roots.mismatches == 0 && roots.roots_due.size() == 0)
            $display("fixed_point_cube_root_newton_test: clean");
        else
            $display("fixed_point_cube_root_newton_test: errors");
        $finish;
    end
endmodule

`default_nettype wire
